### rtl/core/rcf_pkg.sv
package rcf_pkg;

  localparam logic OP_COEF  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_KERNEL_SIZE  = 2'd2;
  localparam logic [1:0] REG_DIVISOR      = 2'd3;

  // signed Q8.8 coefficient times unsigned 8-bit channel
  localparam int PROD_W = 25;

  typedef struct packed {
    logic [10:0] image_width;
    logic [15:0] image_height;
    logic [2:0]  kernel_size;
    logic [15:0] divisor;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic               is_coef;
    logic               emit;
    logic               last;
    logic               bad;
    logic [4:0]         coef_index;
    logic signed [15:0] coef_value;
  } front_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic bad;
  } tag_t;

endpackage

### rtl/core/rcf_pix_if.sv
interface rcf_pix_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [4:0]         coef_index;
  logic signed [15:0] coef_value;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;

  modport source (output valid, operation, coef_index, coef_value, red, green, blue,
                  input ready);
  modport sink (input valid, operation, coef_index, coef_value, red, green, blue,
                output ready);
endinterface

### rtl/core/rcf_res_if.sv
interface rcf_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       last_pixel;
  logic       size_error;

  modport source (output valid, out_red, out_green, out_blue, last_pixel, size_error,
                  input ready);
  modport sink (input valid, out_red, out_green, out_blue, last_pixel, size_error,
                output ready);
endinterface

### rtl/core/rcf_cfg_if.sv
interface rcf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/rgb_convolution_filter_top.sv
// channel | dir | beat carries
// pix     | in  | operation, coef_index, coef_value, red, green, blue
// res     | out | out_red, out_green, out_blue, last_pixel, size_error
// cfg     | in  | index, data (register write, always ready)
//
// One beat per cycle in on pix while res is not stalled.
// The line store (one read and one write port) and a 14-stage pipeline set
// the rate: one pixel per clock, one result per emitting pixel.
// rst is synchronous; counters, coefficients and config return to defaults.
// A stall on res freezes the whole pipeline; pix.ready drops in that cycle.
module rgb_convolution_filter_top #(
  parameter int MAX_KERNEL = 5,
  parameter int MAX_WIDTH  = 1024
) (
  input logic        clk,
  input logic        rst,
  rcf_pix_if.sink    pix,
  rcf_res_if.source  res,
  rcf_cfg_if.sink    cfg
);
  import rcf_pkg::*;

  localparam int ACCW = PROD_W + 2 * $clog2(MAX_KERNEL);

  cfg_t                   regs;
  logic                   en, accept;
  front_t                 ftag;
  logic [23:0]            win [MAX_KERNEL][MAX_KERNEL];
  tag_t                   mtag, dtag;
  logic signed [ACCW-1:0] acc [3];
  logic [7:0]             color [3];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.image_width  <= 11'd640;
      regs.image_height <= 16'd480;
      regs.kernel_size  <= 3'd3;
      regs.divisor      <= 16'd1;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_IMAGE_WIDTH:  regs.image_width  <= cfg.data[10:0];
        REG_IMAGE_HEIGHT: regs.image_height <= cfg.data;
        REG_KERNEL_SIZE:  regs.kernel_size  <= cfg.data[2:0];
        REG_DIVISOR:      regs.divisor      <= cfg.data;
        default: ;
      endcase
    end
  end

  assign en        = !res.valid || res.ready;
  assign pix.ready = en;
  assign accept    = pix.valid && en;

  rcf_front #(.MAX_KERNEL(MAX_KERNEL), .MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk, .rst, .en, .accept,
    .operation (pix.operation),
    .coef_index(pix.coef_index),
    .coef_value(pix.coef_value),
    .red       (pix.red),
    .green     (pix.green),
    .blue      (pix.blue),
    .cfg       (regs),
    .tag       (ftag),
    .win       (win)
  );

  rcf_mac #(.MAX_KERNEL(MAX_KERNEL), .ACCW(ACCW)) u_mac (
    .clk, .rst, .en,
    .tag_in     (ftag),
    .win        (win),
    .kernel_size(regs.kernel_size),
    .tag_out    (mtag),
    .acc        (acc)
  );

  rcf_div #(.ACCW(ACCW)) u_div (
    .clk, .rst, .en,
    .tag_in (mtag),
    .acc    (acc),
    .divisor(regs.divisor),
    .tag_out(dtag),
    .color  (color)
  );

  assign res.valid      = dtag.valid;
  assign res.out_red    = color[0];
  assign res.out_green  = color[1];
  assign res.out_blue   = color[2];
  assign res.last_pixel = dtag.last;
  assign res.size_error = dtag.bad;

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.size_error) |->
      (res.out_red == 8'd0 && res.out_green == 8'd0 && res.out_blue == 8'd0))
    else $error("size error with nonzero color");
  a_rst_empty: assert property (@(posedge clk) rst |=> !res.valid)
    else $error("result valid right after reset");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |-> !pix.ready)
    else $error("input taken while output stalled");
`endif

endmodule

### rtl/core/rcf_front.sv
module rcf_front #(
  parameter int MAX_KERNEL = 5,
  parameter int MAX_WIDTH  = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               accept,
  input  logic               operation,
  input  logic [4:0]         coef_index,
  input  logic signed [15:0] coef_value,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  input  rcf_pkg::cfg_t      cfg,
  output rcf_pkg::front_t    tag,
  output logic [23:0]        win [MAX_KERNEL][MAX_KERNEL]
);
  import rcf_pkg::*;

  localparam int LINES = MAX_KERNEL - 1;
  localparam int LW    = LINES * 24;
  localparam int AW    = $clog2(MAX_WIDTH);

  logic [9:0]    cc;
  logic [15:0]   rc;
  logic [AW-1:0] colm;
  logic [13:0]   w_eff;
  logic [15:0]   h_eff;
  logic          col_end, row_end, bad, emit, acc_pix;
  front_t        s0, s1;
  logic [AW-1:0] s1_col;
  logic [23:0]   s1_pix;
  logic          s1_fwd;
  logic [LW-1:0] s1_fwdd, rd, rd_eff, newcol;
  logic          s1_wr;
  logic [LW-1:0] mem [MAX_WIDTH];

  always_comb begin
    w_eff = (cfg.image_width == 11'd0) ? 14'd1 : 14'(cfg.image_width);
    if (w_eff > 14'(MAX_WIDTH)) w_eff = 14'(MAX_WIDTH);
    h_eff = (cfg.image_height == 16'd0) ? 16'd1 : cfg.image_height;
    col_end = (14'(cc) + 14'd1) >= w_eff;
    row_end = (17'(rc) + 17'd1) >= 17'(h_eff);
    bad = (cfg.kernel_size < 3'd3) || !cfg.kernel_size[0] ||
          (32'(cfg.kernel_size) > MAX_KERNEL);
    emit = bad || (((11'(cc) + 11'd1) >= 11'(cfg.kernel_size)) &&
                   ((17'(rc) + 17'd1) >= 17'(cfg.kernel_size)));
    acc_pix = accept && (operation == OP_PIXEL);
    s0.valid      = accept;
    s0.is_coef    = (operation == OP_COEF);
    s0.emit       = emit;
    s0.last       = col_end && row_end;
    s0.bad        = bad;
    s0.coef_index = coef_index;
    s0.coef_value = coef_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cc   <= '0;
      rc   <= '0;
      colm <= '0;
    end else if (acc_pix) begin
      if (col_end) begin
        cc   <= '0;
        colm <= '0;
        rc   <= row_end ? 16'd0 : rc + 16'd1;
      end else begin
        cc   <= cc + 10'd1;
        colm <= (colm == AW'(MAX_WIDTH - 1)) ? '0 : colm + 1'b1;
      end
    end
  end

  // previous beat writes this column in the same cycle: take its data
  assign rd_eff = s1_fwd ? s1_fwdd : rd;
  assign s1_wr  = en && s1.valid && !s1.is_coef;

  always_comb begin
    for (int r = 0; r < LINES - 1; r++) newcol[r*24 +: 24] = rd_eff[(r+1)*24 +: 24];
    newcol[(LINES-1)*24 +: 24] = s1_pix;
  end

  always_ff @(posedge clk) begin
    if (s1_wr) mem[s1_col] <= newcol;
    if (acc_pix) rd <= mem[colm];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1  <= '0;
      tag <= '0;
    end else if (en) begin
      s1  <= s0;
      tag <= s1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_col  <= colm;
      s1_pix  <= {red, green, blue};
      s1_fwd  <= acc_pix && s1_wr && (colm == s1_col);
      s1_fwdd <= newcol;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_wr) begin
      for (int r = 0; r < MAX_KERNEL; r++) begin
        for (int c = 0; c < MAX_KERNEL - 1; c++) win[r][c] <= win[r][c+1];
        win[r][MAX_KERNEL-1] <= (r < LINES) ? rd_eff[r*24 +: 24] : s1_pix;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_colm_range: assert property (@(posedge clk) disable iff (rst)
    colm <= AW'(MAX_WIDTH - 1))
    else $error("line store column out of range");
  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    (acc_pix && col_end) |=> (cc == 10'd0))
    else $error("column count not cleared at end of row");
  a_fwd_src: assert property (@(posedge clk) disable iff (rst)
    s1_fwd |-> $past(s1.valid && !s1.is_coef))
    else $error("forward without a preceding pixel");
`endif

endmodule

### rtl/core/rcf_mac.sv
module rcf_mac #(
  parameter int MAX_KERNEL = 5,
  parameter int ACCW       = 31
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  rcf_pkg::front_t        tag_in,
  input  logic [23:0]            win [MAX_KERNEL][MAX_KERNEL],
  input  logic [2:0]             kernel_size,
  output rcf_pkg::tag_t          tag_out,
  output logic signed [ACCW-1:0] acc [3]
);
  import rcf_pkg::*;

  localparam int NT  = MAX_KERNEL * MAX_KERNEL;
  localparam int CIW = $clog2(NT);
  localparam int RW  = PROD_W + $clog2(MAX_KERNEL);

  logic signed [15:0]     coef_table [NT];
  logic signed [15:0]     ecoef [NT];
  logic                   ksel [NT];
  logic signed [PROD_W-1:0] prod_c [3][NT];
  logic signed [PROD_W-1:0] prod_r [3][NT];
  logic signed [RW-1:0]   row_c [3][MAX_KERNEL];
  logic signed [RW-1:0]   row_r [3][MAX_KERNEL];
  logic signed [ACCW-1:0] acc_c [3];
  tag_t                   t3, t4;
  logic [CIW-1:0]         widx;

  assign widx = CIW'(tag_in.coef_index);

  // coefficient writes land in order with the products that read them
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NT; i++) coef_table[i] <= '0;
    end else if (en && tag_in.valid && tag_in.is_coef && (32'(tag_in.coef_index) < NT)) begin
      coef_table[widx] <= tag_in.coef_value;
    end
  end

  always_comb begin
    int base;
    int idx;
    base = MAX_KERNEL - int'(kernel_size);
    for (int r = 0; r < MAX_KERNEL; r++) begin
      for (int c = 0; c < MAX_KERNEL; c++) begin
        ecoef[r*MAX_KERNEL+c] = '0;
        ksel[r*MAX_KERNEL+c]  = 1'b0;
        idx = (r - base) * int'(kernel_size) + (c - base);
        if (r >= base && c >= base && idx >= 0 && idx < NT) begin
          ecoef[r*MAX_KERNEL+c] = coef_table[CIW'(idx)];
          ksel[r*MAX_KERNEL+c]  = 1'b1;
        end
      end
    end
  end

  // taps outside the kernel may hold lines never written; force them to zero
  always_comb begin
    for (int r = 0; r < MAX_KERNEL; r++) begin
      for (int c = 0; c < MAX_KERNEL; c++) begin
        for (int ch = 0; ch < 3; ch++) begin
          prod_c[ch][r*MAX_KERNEL+c] = ksel[r*MAX_KERNEL+c] ?
            PROD_W'(ecoef[r*MAX_KERNEL+c] * $signed({1'b0, win[r][c][(2-ch)*8 +: 8]})) :
            '0;
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < MAX_KERNEL; r++) begin
        row_c[ch][r] = '0;
        for (int c = 0; c < MAX_KERNEL; c++)
          row_c[ch][r] = row_c[ch][r] + RW'(prod_r[ch][r*MAX_KERNEL+c]);
      end
      acc_c[ch] = '0;
      for (int r = 0; r < MAX_KERNEL; r++) acc_c[ch] = acc_c[ch] + ACCW'(row_r[ch][r]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t3      <= '0;
      t4      <= '0;
      tag_out <= '0;
    end else if (en) begin
      t3.valid <= tag_in.valid && !tag_in.is_coef && tag_in.emit;
      t3.last  <= tag_in.last;
      t3.bad   <= tag_in.bad;
      t4       <= t3;
      tag_out  <= t4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_c;
      row_r  <= row_c;
      acc    <= acc_c;
    end
  end

endmodule

### rtl/core/rcf_div.sv
module rcf_div #(
  parameter int ACCW = 31
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  rcf_pkg::tag_t          tag_in,
  input  logic signed [ACCW-1:0] acc [3],
  input  logic [15:0]            divisor,
  output rcf_pkg::tag_t          tag_out,
  output logic [7:0]             color [3]
);
  import rcf_pkg::*;

  localparam int NW = ACCW - 8;
  localparam int CW = ((NW > 24) ? NW : 24) + 1;

  logic [15:0]   d_eff;
  tag_t          t_p   [9];
  logic [NW-1:0] rem_p [9][3];
  logic [7:0]    q_p   [9][3];
  logic          sat_p [9][3];
  logic          zro_p [9][3];

  assign d_eff = (divisor == 16'd0) ? 16'd1 : divisor;

  // floor(acc / (d*256)) == floor(floor(acc/256) / d); saturate early
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < 9; j++) t_p[j] <= '0;
    end else if (en) begin
      t_p[0] <= tag_in;
      for (int j = 0; j < 8; j++) t_p[j+1] <= t_p[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int ch = 0; ch < 3; ch++) begin
        rem_p[0][ch] <= NW'(acc[ch][ACCW-1:8]);
        q_p[0][ch]   <= '0;
        zro_p[0][ch] <= acc[ch][ACCW-1] || (acc[ch] == '0);
        sat_p[0][ch] <= CW'(acc[ch][ACCW-1:8]) >= (CW'(d_eff) << 8);
      end
      // one quotient bit per stage, most significant first
      for (int j = 0; j < 8; j++) begin
        for (int ch = 0; ch < 3; ch++) begin
          sat_p[j+1][ch] <= sat_p[j][ch];
          zro_p[j+1][ch] <= zro_p[j][ch];
          if (CW'(rem_p[j][ch]) >= (CW'(d_eff) << (7 - j))) begin
            rem_p[j+1][ch] <= NW'(CW'(rem_p[j][ch]) - (CW'(d_eff) << (7 - j)));
            q_p[j+1][ch]   <= q_p[j][ch] | (8'd1 << (7 - j));
          end else begin
            rem_p[j+1][ch] <= rem_p[j][ch];
            q_p[j+1][ch]   <= q_p[j][ch];
          end
        end
      end
    end
  end

  assign tag_out = t_p[8];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      if (t_p[8].bad || zro_p[8][ch]) color[ch] = 8'd0;
      else if (sat_p[8][ch]) color[ch] = 8'd255;
      else color[ch] = q_p[8][ch];
    end
  end

endmodule

### test/tb.sv
`timescale 1ns / 100ps

module tb;
  import rcf_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int LINE_W = 1024;
  localparam int KMAX = 5;

  typedef struct {
    logic        operation;
    logic [4:0]  coef_index;
    logic [15:0] coef_value;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } pix_item_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
    logic       size_error;
  } filt_px_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rcf_pix_if pix ();
  rcf_res_if res ();
  rcf_cfg_if cfg ();

  rgb_convolution_filter_top dut (
    .clk(clk),
    .rst(rst),
    .pix(pix),
    .res(res),
    .cfg(cfg)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pix_item_t pending_q[$];
  filt_px_t  filtered_q[$];
  pix_item_t cur_item;
  int        fail_cnt = 0;
  int        pushed_cnt = 0;
  int        cycle_cnt = 0;
  bit        quiet = 1'b0;
  bit        pix_fire = 1'b0;
  bit        hold_go = 1'b0;
  bit        hold_seen = 1'b0;
  int        hold_cnt = 0;

  // filter state mirror
  int              img_w = 640, img_h = 480, ksize = 3, div_reg = 1;
  bit signed [15:0] coef_tab[25];
  bit [23:0]       line_mem[KMAX-1][LINE_W];
  bit [23:0]       win[KMAX][KMAX];
  int              col_cnt = 0, row_cnt = 0;

  function automatic logic [7:0] clamp_channel(longint acc, int dv);
    longint q;
    if (acc <= 0) return 8'd0;
    q = acc / (longint'(dv) * 256);
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  task automatic convolve_pixel(pix_item_t it);
    int w, h, dv, k, c, base;
    bit bad, last, emit;
    bit [23:0] colv[KMAX];
    bit [23:0] p;
    longint acc_r, acc_g, acc_b, cf;
    filt_px_t e;
    if (it.operation == OP_COEF) begin
      if (it.coef_index < 25) coef_tab[it.coef_index] = it.coef_value;
      return;
    end
    w = (img_w == 0) ? 1 : img_w;
    if (w > LINE_W) w = LINE_W;
    h = (img_h == 0) ? 1 : img_h;
    dv = (div_reg == 0) ? 1 : div_reg;
    k = ksize;
    bad = (k < 3) || (k % 2 == 0) || (k > KMAX);
    p = {it.red, it.green, it.blue};
    c = col_cnt % LINE_W;
    for (int r = 0; r < KMAX - 1; r++) colv[r] = line_mem[r][c];
    colv[KMAX-1] = p;
    for (int r = 0; r < KMAX - 2; r++) line_mem[r][c] = line_mem[r+1][c];
    line_mem[KMAX-2][c] = p;
    for (int r = 0; r < KMAX; r++) begin
      for (int j = 0; j < KMAX - 1; j++) win[r][j] = win[r][j+1];
      win[r][KMAX-1] = colv[r];
    end
    last = (col_cnt + 1 >= w) && (row_cnt + 1 >= h);
    emit = bad || (col_cnt + 1 >= k && row_cnt + 1 >= k);
    if (emit) begin
      e = '{default: '0};
      if (!bad) begin
        acc_r = 0; acc_g = 0; acc_b = 0;
        base = KMAX - k;
        for (int r = 0; r < k; r++)
          for (int j = 0; j < k; j++) begin
            cf = coef_tab[r*k + j];
            acc_r += cf * win[base+r][base+j][23:16];
            acc_g += cf * win[base+r][base+j][15:8];
            acc_b += cf * win[base+r][base+j][7:0];
          end
        e.red = clamp_channel(acc_r, dv);
        e.green = clamp_channel(acc_g, dv);
        e.blue = clamp_channel(acc_b, dv);
      end
      e.last_pixel = last;
      e.size_error = bad;
      filtered_q.push_back(e);
    end
    if (col_cnt + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1 >= h) ? 0 : ((row_cnt + 1) & 16'hFFFF);
    end else begin
      col_cnt = (col_cnt + 1) & 10'h3FF;
    end
  endtask

  // input side
  int drv_gap = 0;
  always @(posedge clk) begin
    pix_fire <= pix.valid && pix.ready;
    if (pix.valid && pix.ready) convolve_pixel(cur_item);
  end

  always @(negedge clk) begin
    if (!rst && (!pix.valid || pix_fire)) begin
      if (drv_gap > 0) begin
        drv_gap--;
        pix.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        drv_gap = $urandom_range(0, 3);
        pix.valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        cur_item = pending_q.pop_front();
        pix.operation <= cur_item.operation;
        pix.coef_index <= cur_item.coef_index;
        pix.coef_value <= cur_item.coef_value;
        pix.red <= cur_item.red;
        pix.green <= cur_item.green;
        pix.blue <= cur_item.blue;
        pix.valid <= 1'b1;
      end else begin
        pix.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted here
  always @(negedge clk) begin
    if (hold_go && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_cnt <= 300;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // output side
  int mon_gap = 0;
  always @(negedge clk) begin
    if (hold_cnt > 0 || (hold_go && !hold_seen)) begin
      res.ready <= 1'b0;
    end else if (mon_gap > 0) begin
      mon_gap--;
      res.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      mon_gap = $urandom_range(0, 3);
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    filt_px_t e;
    if (!rst && res.valid && res.ready) begin
      if (filtered_q.size() == 0) begin
        $display("%0t: unexpected result r=%0d g=%0d b=%0d last=%0b err=%0b", $time,
                 res.out_red, res.out_green, res.out_blue, res.last_pixel, res.size_error);
        fail_cnt++;
      end else begin
        e = filtered_q.pop_front();
        if (res.out_red !== e.red) begin
          $display("%0t: out_red expected %0d got %0d", $time, e.red, res.out_red);
          fail_cnt++;
        end
        if (res.out_green !== e.green) begin
          $display("%0t: out_green expected %0d got %0d", $time, e.green, res.out_green);
          fail_cnt++;
        end
        if (res.out_blue !== e.blue) begin
          $display("%0t: out_blue expected %0d got %0d", $time, e.blue, res.out_blue);
          fail_cnt++;
        end
        if (res.last_pixel !== e.last_pixel) begin
          $display("%0t: last_pixel expected %0b got %0b", $time, e.last_pixel,
                   res.last_pixel);
          fail_cnt++;
        end
        if (res.size_error !== e.size_error) begin
          $display("%0t: size_error expected %0b got %0b", $time, e.size_error,
                   res.size_error);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("rgb_convolution_filter_top test failed");
      $finish;
    end
  end

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_coef(int idx, logic [15:0] val);
    pix_item_t it;
    it = '{OP_COEF, 5'(idx), val, 8'($urandom), 8'($urandom), 8'($urandom)};
    pending_q.push_back(it);
    pushed_cnt++;
  endtask

  // raster frame; when noisy, a few coefficient loads land mid-frame
  task automatic push_frame(int w, int h, bit noisy);
    pix_item_t it;
    for (int i = 0; i < w * h; i++) begin
      if (noisy && $urandom_range(0, 29) == 0)
        push_coef($urandom_range(0, 31), 16'($urandom));
      it = '{OP_PIXEL, 5'($urandom), 16'($urandom), pick_channel(), pick_channel(),
             pick_channel()};
      pending_q.push_back(it);
      pushed_cnt++;
    end
  endtask

  task automatic load_kernel(int k, int scale);
    for (int i = 0; i < k * k; i++)
      push_coef(i, (scale == 0) ? 16'($urandom) : 16'($urandom_range(0, 2*scale) - scale));
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || pix.valid || filtered_q.size() != 0) @(posedge clk);
    // coefficient beats leave no result; let the pipeline empty
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg.index <= idx;
    cfg.data <= val;
    cfg.valid <= 1'b1;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH:  img_w = int'(val & 16'h7FF);
      REG_IMAGE_HEIGHT: img_h = int'(val);
      REG_KERNEL_SIZE:  ksize = int'(val & 16'h7);
      default:          div_reg = int'(val);
    endcase
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic set_filter(int w, int h, int k, int dv);
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, 16'(w));
    write_reg(REG_IMAGE_HEIGHT, 16'(h));
    write_reg(REG_KERNEL_SIZE, 16'(k));
    write_reg(REG_DIVISOR, 16'(dv));
  endtask

  initial begin
    int w, h, k, dv;
    pix.valid = 1'b0;
    pix.operation = OP_PIXEL;
    pix.coef_index = '0;
    pix.coef_value = '0;
    pix.red = '0;
    pix.green = '0;
    pix.blue = '0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = REG_IMAGE_WIDTH;
    cfg.data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // identity 3x3, plus an out-of-range index that must be dropped
    set_filter(4, 4, 3, 1);
    for (int i = 0; i < 9; i++) push_coef(i, (i == 4) ? 16'h0100 : 16'h0000);
    push_coef(31, 16'h8000);
    push_frame(4, 4, 1'b0);

    // 5x5 with extreme coefficients, zero divisor
    set_filter(5, 5, 5, 0);
    push_coef(0, 16'h8000);
    push_coef(24, 16'h7FFF);
    push_coef(12, 16'h0100);
    push_frame(5, 5, 1'b0);

    // invalid sizes and degenerate frame sizes
    set_filter(0, 0, 0, 65535);
    push_frame(1, 1, 1'b0);
    set_filter(1, 3, 1, 1);
    push_frame(1, 3, 1'b0);
    // wide row cut short, then closed by shrinking the width
    set_filter(2047, 1, 6, 2);
    push_frame(200, 1, 1'b0);
    set_filter(3, 1, 6, 2);
    push_frame(1, 1, 1'b0);
    set_filter(3, 2, 7, 3);
    push_frame(3, 2, 1'b0);

    // tall frame cut short, then closed by shrinking the height
    set_filter(4, 65535, 2, 1);
    push_frame(4, 3, 1'b0);
    set_filter(4, 1, 4, 1);
    push_frame(4, 1, 1'b0);

    // fill up the pipeline against a stalled receiver
    set_filter(8, 8, 3, 1);
    load_kernel(3, 64);
    hold_go = 1'b1;
    push_frame(8, 8, 1'b1);

    while (pushed_cnt < 480) begin
      w = $urandom_range(3, 12);
      h = $urandom_range(3, 8);
      case ($urandom_range(0, 9))
        0: k = 4;
        1, 2, 3, 4: k = 5;
        default: k = 3;
      endcase
      if (k == 5) begin
        w = $urandom_range(5, 12);
        h = $urandom_range(5, 8);
      end
      case ($urandom_range(0, 5))
        0: dv = 0;
        1: dv = 65535;
        2: dv = $urandom_range(2, 40);
        default: dv = 1;
      endcase
      set_filter(w, h, k, dv);
      load_kernel(5, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(16, 300));
      push_frame(w, h, 1'b1);
      if ($urandom_range(0, 2) == 0) push_frame(w, h, 1'b1);
    end

    // last stretch at full rate
    set_filter(9, 6, 3, 1);
    quiet = 1'b1;
    load_kernel(3, 128);
    push_frame(9, 6, 1'b1);

    wait_drained();
    if (fail_cnt == 0) begin
      $display("rgb_convolution_filter_top test passed");
    end else begin
      $display("rgb_convolution_filter_top test failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/rcf_pkg.sv
rtl/core/rcf_pix_if.sv
rtl/core/rcf_res_if.sv
rtl/core/rcf_cfg_if.sv
rtl/core/rcf_front.sv
rtl/core/rcf_mac.sv
rtl/core/rcf_div.sv
rtl/core/rgb_convolution_filter_top.sv
test/tb.sv
